/* rtl/srj_pkg.sv */
// Package: payload types, fixed-point helpers and divider step for the reprojection block.
package srj_pkg;

    localparam int QW = 32;
    localparam int CFGW = 31;
    localparam int NUMW = 48;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_STAGES = NUMW / DIV_STEP_BITS;
    localparam int LANES = 3;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [CFGW-1:0] FOCAL_X_RST = 31'd32768000;
    localparam logic [CFGW-1:0] FOCAL_Y_RST = 31'd32768000;
    localparam logic [CFGW-1:0] CENTER_X_RST = 31'd20971520;
    localparam logic [CFGW-1:0] CENTER_Y_RST = 31'd15728640;
    localparam logic [CFGW-1:0] BASELINE_RST = 31'd0;

    typedef enum logic [2:0] {
        REG_FOCAL_X = 3'd0,
        REG_FOCAL_Y = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_BASELINE = 3'd4,
        REG_STEREO = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROW_U = 2'd0,
        ROW_V = 2'd1,
        ROW_RIGHT = 2'd2
    } row_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] obs_u;
        logic signed [31:0] obs_v;
        logic signed [31:0] obs_right_u;
    } point_t;

    typedef struct packed {
        logic [1:0] row_index;
        logic signed [31:0] residual;
        logic signed [31:0] jac_rot_x;
        logic signed [31:0] jac_rot_y;
        logic signed [31:0] jac_rot_z;
        logic signed [31:0] jac_trans_x;
        logic signed [31:0] jac_trans_y;
        logic signed [31:0] jac_trans_z;
        logic depth_positive;
        logic last_row;
    } result_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [NUMW-1:0] num;
        logic [NUMW-1:0] quo;
    } div_lane_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
            r = S32_MAX;
        else if (v < -33'sh0_8000_0000)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] p,
                                                input logic signed [31:0] q);
        logic signed [32:0] s;
        s = {p[31], p} + {q[31], q};
        return sat33(s);
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] p,
                                                input logic signed [31:0] q);
        logic signed [32:0] s;
        s = {p[31], p} - {q[31], q};
        return sat33(s);
    endfunction

    function automatic logic signed [31:0] qneg(input logic signed [31:0] p);
        logic signed [32:0] s;
        s = -{p[31], p};
        return sat33(s);
    endfunction

    // floor((p*q) / 2^16), saturated
    function automatic logic signed [31:0] qmul(input logic signed [31:0] p,
                                                input logic signed [31:0] q);
        logic signed [63:0] prod;
        logic signed [47:0] r;
        logic signed [31:0] o;
        prod = p * q;
        r = prod[63:16];
        if (r > 48'sh0000_7FFF_FFFF)
            o = S32_MAX;
        else if (r < -48'sh0000_8000_0000)
            o = S32_MIN;
        else
            o = r[31:0];
        return o;
    endfunction

    // restoring division, DIV_STEP_BITS quotient bits
    function automatic div_lane_t div_step(input div_lane_t l, input logic [31:0] d);
        div_lane_t o;
        logic [32:0] r;
        o = l;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            r = {o.rem, o.num[NUMW-1]};
            o.num = {o.num[NUMW-2:0], 1'b0};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                o.quo = {o.quo[NUMW-2:0], 1'b1};
            end else begin
                o.quo = {o.quo[NUMW-2:0], 1'b0};
            end
            o.rem = r[31:0];
        end
        return o;
    endfunction

endpackage

/* rtl/stereo_reprojection_jacobian.sv */
// Top level: pinhole reprojection residual and pose Jacobian pipeline.
//
// Usage:
//   Input: present a point on 'point' and raise 'start'; the item is taken at a
//   clock edge with start high and busy low. busy goes high after each accepted
//   item, and the next item is taken only once busy is low again.
//   Output: each item yields 3 rows (stereo_reg = 1) or 2 rows (mono), one per
//   cycle on 'result', each marked by result_valid high in its cycle; last_row
//   flags the final row. The receiver cannot stall.
//   Pipeline: a 24-stage radix-4 divider for x/z, y/z, 1/z, then a saturation
//   stage, two multiply stages and a combine stage, then the row output register.
//   A new item can enter while earlier items are still in flight; the busy
//   spacing keeps the single-row result channel from overrunning.
//   Configuration: cfg_write/cfg_index/cfg_data write one register per cycle;
//   write only while no item is in flight.
//   Reset: registers return to their defaults and the pipeline empties; busy
//   is low out of reset, so the block accepts an item as soon as reset ends.
module stereo_reprojection_jacobian
    import srj_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  point_t         point,
    output logic           result_valid,
    output result_t        result,
    input  logic           cfg_write,
    input  logic [2:0]     cfg_index,
    input  logic [CFGW-1:0] cfg_data
);

    logic [CFGW-1:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg, baseline_reg;
    logic stereo_reg;
    logic [1:0] busy_cnt_reg;
    logic accept;

    logic signed [31:0] fx, fy, cx, cy, bf;

    assign fx = {1'b0, focal_x_reg};
    assign fy = {1'b0, focal_y_reg};
    assign cx = {1'b0, center_x_reg};
    assign cy = {1'b0, center_y_reg};
    assign bf = {1'b0, baseline_reg};

    assign busy = (busy_cnt_reg != 2'd0);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg <= FOCAL_X_RST;
            focal_y_reg <= FOCAL_Y_RST;
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            baseline_reg <= BASELINE_RST;
            stereo_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FOCAL_X:  focal_x_reg <= cfg_data;
                REG_FOCAL_Y:  focal_y_reg <= cfg_data;
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_BASELINE: baseline_reg <= cfg_data;
                REG_STEREO:   stereo_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_cnt_reg <= 2'd0;
        else if (accept)
            busy_cnt_reg <= 2'd2;
        else if (busy)
            busy_cnt_reg <= busy_cnt_reg - 2'd1;
    end

    // divider pipeline
    logic            dv_valid_reg [0:DIV_STAGES];
    point_t          dv_pt_reg    [0:DIV_STAGES];
    logic [31:0]     dv_dmag_reg  [0:DIV_STAGES];
    div_lane_t       dv_lane_reg  [0:DIV_STAGES][LANES];

    logic [31:0] zmag;
    logic signed [NUMW-1:0] n_ext [LANES];
    div_lane_t lane_init [LANES];

    always_comb
    begin
        zmag = point.point_z[31] ? 32'(-point.point_z) : 32'(point.point_z);
        n_ext[0] = {point.point_x, 16'd0};
        n_ext[1] = {point.point_y, 16'd0};
        n_ext[2] = {Q_ONE, 16'd0};
        for (int k = 0; k < LANES; k++)
        begin
            lane_init[k].rem = '0;
            lane_init[k].quo = '0;
            lane_init[k].num = n_ext[k][NUMW-1] ? NUMW'(-n_ext[k]) : NUMW'(n_ext[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else
            dv_valid_reg[0] <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dv_pt_reg[0] <= point;
            dv_dmag_reg[0] <= zmag;
            for (int k = 0; k < LANES; k++)
                dv_lane_reg[0][k] <= lane_init[k];
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[s+1] <= 1'b0;
            else
                dv_valid_reg[s+1] <= dv_valid_reg[s];
        end

        always_ff @(posedge clk)
        begin
            dv_pt_reg[s+1] <= dv_pt_reg[s];
            dv_dmag_reg[s+1] <= dv_dmag_reg[s];
            for (int k = 0; k < LANES; k++)
                dv_lane_reg[s+1][k] <= div_step(dv_lane_reg[s][k], dv_dmag_reg[s]);
        end
    end

    // sign, saturation and zero-depth handling of the quotients
    function automatic logic signed [31:0] div_final(input logic [NUMW-1:0] quo,
                                                     input logic signed [31:0] n,
                                                     input logic signed [31:0] d);
        logic signed [31:0] r;
        logic neg;
        neg = n[31] ^ d[31];
        if (d == 32'sd0)
        begin
            if (n > 32'sd0)
                r = S32_MAX;
            else if (n < 32'sd0)
                r = S32_MIN;
            else
                r = 32'sd0;
        end
        else if (!neg)
            r = (quo > NUMW'(32'h7FFF_FFFF)) ? S32_MAX : quo[31:0];
        else
            r = (quo > NUMW'(32'h8000_0000)) ? S32_MIN : 32'(-quo[31:0]);
        return r;
    endfunction

    logic fq_valid_reg;
    point_t fq_pt_reg;
    logic signed [31:0] fq_a_reg, fq_b_reg, fq_iz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fq_valid_reg <= 1'b0;
        else
            fq_valid_reg <= dv_valid_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        fq_pt_reg <= dv_pt_reg[DIV_STAGES];
        fq_a_reg <= div_final(dv_lane_reg[DIV_STAGES][0].quo,
                              dv_pt_reg[DIV_STAGES].point_x, dv_pt_reg[DIV_STAGES].point_z);
        fq_b_reg <= div_final(dv_lane_reg[DIV_STAGES][1].quo,
                              dv_pt_reg[DIV_STAGES].point_y, dv_pt_reg[DIV_STAGES].point_z);
        fq_iz_reg <= div_final(dv_lane_reg[DIV_STAGES][2].quo,
                               Q_ONE, dv_pt_reg[DIV_STAGES].point_z);
    end

    // first product level
    logic m1_valid_reg;
    point_t m1_pt_reg;
    logic signed [31:0] m1_iz_reg, m1_aa_reg, m1_bb_reg, m1_ab_reg, m1_iz2_reg;
    logic signed [31:0] m1_ai_reg, m1_bi_reg, m1_afx_reg, m1_bfy_reg, m1_bfb_reg;
    logic signed [31:0] m1_bfa_reg, m1_bfx_reg, m1_izfx_reg, m1_izfy_reg;
    logic signed [31:0] m1_afy_reg, m1_bfiz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else
            m1_valid_reg <= fq_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        m1_pt_reg <= fq_pt_reg;
        m1_iz_reg <= fq_iz_reg;
        m1_aa_reg <= qmul(fq_a_reg, fq_a_reg);
        m1_bb_reg <= qmul(fq_b_reg, fq_b_reg);
        m1_ab_reg <= qmul(fq_a_reg, fq_b_reg);
        m1_iz2_reg <= qmul(fq_iz_reg, fq_iz_reg);
        m1_ai_reg <= qmul(fq_a_reg, fq_iz_reg);
        m1_bi_reg <= qmul(fq_b_reg, fq_iz_reg);
        m1_afx_reg <= qmul(fq_a_reg, fx);
        m1_bfy_reg <= qmul(fq_b_reg, fy);
        m1_bfb_reg <= qmul(bf, fq_b_reg);
        m1_bfa_reg <= qmul(bf, fq_a_reg);
        m1_bfx_reg <= qmul(fq_b_reg, fx);
        m1_izfx_reg <= qmul(fq_iz_reg, fx);
        m1_izfy_reg <= qmul(fq_iz_reg, fy);
        m1_afy_reg <= qmul(fq_a_reg, fy);
        m1_bfiz_reg <= qmul(bf, fq_iz_reg);
    end

    // second product level
    logic m2_valid_reg;
    point_t m2_pt_reg;
    logic signed [31:0] m2_j00_reg, m2_t01_reg, m2_j02_reg, m2_t03_reg, m2_j05_reg;
    logic signed [31:0] m2_j10_reg, m2_t11_reg, m2_t12_reg, m2_t14_reg, m2_j15_reg;
    logic signed [31:0] m2_c20_reg, m2_c21_reg, m2_c25_reg, m2_pu_reg, m2_pv_reg;
    logic signed [31:0] m2_bfiz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_valid_reg <= 1'b0;
        else
            m2_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        m2_pt_reg <= m1_pt_reg;
        m2_j00_reg <= qmul(m1_ab_reg, fx);
        m2_t01_reg <= qmul(qadd(Q_ONE, m1_aa_reg), fx);
        m2_j02_reg <= m1_bfx_reg;
        m2_t03_reg <= m1_izfx_reg;
        m2_j05_reg <= qmul(m1_ai_reg, fx);
        m2_j10_reg <= qmul(qadd(Q_ONE, m1_bb_reg), fy);
        m2_t11_reg <= qmul(m1_ab_reg, fy);
        m2_t12_reg <= m1_afy_reg;
        m2_t14_reg <= m1_izfy_reg;
        m2_j15_reg <= qmul(m1_bi_reg, fy);
        m2_c20_reg <= qmul(m1_bfb_reg, m1_iz_reg);
        m2_c21_reg <= qmul(m1_bfa_reg, m1_iz_reg);
        m2_c25_reg <= qmul(bf, m1_iz2_reg);
        m2_pu_reg <= qadd(m1_afx_reg, cx);
        m2_pv_reg <= qadd(m1_bfy_reg, cy);
        m2_bfiz_reg <= m1_bfiz_reg;
    end

    // combine into rows
    result_t row_u, row_v, row_r;
    logic dpos;
    logic signed [31:0] nt01, nt03;

    always_comb
    begin
        dpos = !m2_pt_reg.point_z[31] && (m2_pt_reg.point_z != 32'sd0);
        nt01 = qneg(m2_t01_reg);
        nt03 = qneg(m2_t03_reg);

        row_u.row_index = ROW_U;
        row_u.residual = qsub(m2_pt_reg.obs_u, m2_pu_reg);
        row_u.jac_rot_x = m2_j00_reg;
        row_u.jac_rot_y = nt01;
        row_u.jac_rot_z = m2_j02_reg;
        row_u.jac_trans_x = nt03;
        row_u.jac_trans_y = 32'sd0;
        row_u.jac_trans_z = m2_j05_reg;
        row_u.depth_positive = dpos;
        row_u.last_row = 1'b0;

        row_v.row_index = ROW_V;
        row_v.residual = qsub(m2_pt_reg.obs_v, m2_pv_reg);
        row_v.jac_rot_x = m2_j10_reg;
        row_v.jac_rot_y = qneg(m2_t11_reg);
        row_v.jac_rot_z = qneg(m2_t12_reg);
        row_v.jac_trans_x = 32'sd0;
        row_v.jac_trans_y = qneg(m2_t14_reg);
        row_v.jac_trans_z = m2_j15_reg;
        row_v.depth_positive = dpos;
        row_v.last_row = !stereo_reg;

        row_r.row_index = ROW_RIGHT;
        row_r.residual = qsub(m2_pt_reg.obs_right_u, qsub(m2_pu_reg, m2_bfiz_reg));
        row_r.jac_rot_x = qsub(m2_j00_reg, m2_c20_reg);
        row_r.jac_rot_y = qadd(nt01, m2_c21_reg);
        row_r.jac_rot_z = m2_j02_reg;
        row_r.jac_trans_x = nt03;
        row_r.jac_trans_y = 32'sd0;
        row_r.jac_trans_z = qsub(m2_j05_reg, m2_c25_reg);
        row_r.depth_positive = dpos;
        row_r.last_row = 1'b1;
    end

    logic m3_valid_reg;
    result_t m3_row_reg [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m3_valid_reg <= 1'b0;
        else
            m3_valid_reg <= m2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        m3_row_reg[0] <= row_u;
        m3_row_reg[1] <= row_v;
        m3_row_reg[2] <= row_r;
    end

    // row output: rows leave one per cycle; items are spaced by the busy counter
    result_t hold_reg [2];
    logic [1:0] left_reg;
    logic sel_reg;
    result_t result_reg;
    logic result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
            sel_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (m3_valid_reg)
        begin
            left_reg <= stereo_reg ? 2'd2 : 2'd1;
            sel_reg <= 1'b0;
            result_valid_reg <= 1'b1;
        end
        else if (left_reg != 2'd0)
        begin
            left_reg <= left_reg - 2'd1;
            sel_reg <= 1'b1;
            result_valid_reg <= 1'b1;
        end
        else
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m3_valid_reg)
        begin
            result_reg <= m3_row_reg[0];
            hold_reg[0] <= m3_row_reg[1];
            hold_reg[1] <= m3_row_reg[2];
        end
        else if (left_reg != 2'd0)
        begin
            result_reg <= hold_reg[sel_reg];
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule
